FILE: rtl/rths_pkg.sv
// ----------------------------------------------------------------------------
// rths_pkg
// Shared types, codes and widths for the relay/triac hybrid switch sequencer.
// ----------------------------------------------------------------------------
package rths_pkg;

   // elapsed-time counter width (8 to 32)
   localparam int TIME_BITS   = 24;
   localparam int TICK_BITS   = 16;
   localparam int DELAY_BITS  = 24;
   localparam int SUM_BITS    = ((TIME_BITS > TICK_BITS) ? TIME_BITS : TICK_BITS) + 1;
   localparam int CMP_BITS    = (TIME_BITS > DELAY_BITS) ? TIME_BITS : DELAY_BITS;

   localparam int REQ_DATA_BITS = 8;
   localparam int RSP_DATA_BITS = 8;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 24;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_TICK_PERIOD   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RELAY_TOGGLE  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TRIAC_RELEASE = 2'd2;

   localparam logic [TICK_BITS-1:0] TICK_PERIOD_RESET = 16'd1;

   // channel status codes
   localparam logic [1:0] ST_OFF   = 2'd0;
   localparam logic [1:0] ST_ON    = 2'd1;
   localparam logic [1:0] ST_TRANS = 2'd2;

   // reported phase codes
   localparam logic [2:0] PC_IDLE      = 3'd0;
   localparam logic [2:0] PC_TRIAC_ON  = 3'd1;
   localparam logic [2:0] PC_RELAY_ON  = 3'd2;
   localparam logic [2:0] PC_RELAY_OFF = 3'd3;
   localparam logic [2:0] PC_TRIAC_OFF = 3'd4;

   typedef enum logic [4:0] {
      PH_IDLE      = 5'b00001,
      PH_TRIAC_ON  = 5'b00010,
      PH_RELAY_ON  = 5'b00100,
      PH_RELAY_OFF = 5'b01000,
      PH_TRIAC_OFF = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [TICK_BITS-1:0]  tick_period;
      logic [DELAY_BITS-1:0] relay_toggle_delay;
      logic [DELAY_BITS-1:0] triac_release_delay;
   } cfg_type;

   typedef struct packed {
      logic [2:0] phase_now;
      logic [1:0] channel_status;
      logic       relay_drive;
      logic       triac_drive;
   } result_type;

   function automatic logic [2:0] phase_code(input phase_type ph);
      logic [2:0] code;
      case (ph)
         PH_TRIAC_ON:  code = PC_TRIAC_ON;
         PH_RELAY_ON:  code = PC_RELAY_ON;
         PH_RELAY_OFF: code = PC_RELAY_OFF;
         PH_TRIAC_OFF: code = PC_TRIAC_OFF;
         default:      code = PC_IDLE;
      endcase
      return code;
   endfunction

endpackage

FILE: rtl/rths_csr.sv
// ----------------------------------------------------------------------------
// rths_csr
// Configuration register bank: tick period and the two transition delays.
// ----------------------------------------------------------------------------
module rths_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rths_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [rths_pkg::CSR_DATA_BITS-1:0] csr_data,
   output rths_pkg::cfg_type                  cfg
);

   rths_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            rths_pkg::CSR_TICK_PERIOD:
               cfg_in.tick_period = csr_data[rths_pkg::TICK_BITS-1:0];
            rths_pkg::CSR_RELAY_TOGGLE:
               cfg_in.relay_toggle_delay = csr_data[rths_pkg::DELAY_BITS-1:0];
            rths_pkg::CSR_TRIAC_RELEASE:
               cfg_in.triac_release_delay = csr_data[rths_pkg::DELAY_BITS-1:0];
            default: ;  // unmapped index: ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tick_period         <= rths_pkg::TICK_PERIOD_RESET;
         cfg_ff.relay_toggle_delay  <= '0;
         cfg_ff.triac_release_delay <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/rths_seq.sv
// ----------------------------------------------------------------------------
// rths_seq
// Phase sequencer: drive/status from the current phase, saturating elapsed
// counter, then phase advance. One word per cycle while accept is high.
// ----------------------------------------------------------------------------
module rths_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic                   wanted_on,
   input  rths_pkg::cfg_type      cfg,
   output rths_pkg::result_type   result
);

   rths_pkg::phase_type             phase_ff, phase_in;
   logic [rths_pkg::TIME_BITS-1:0]  elapsed_ff, elapsed_in;
   logic                            real_level_ff, real_level_in;

   logic [rths_pkg::SUM_BITS-1:0]   sum;
   logic [rths_pkg::TIME_BITS-1:0]  elapsed_step;
   logic                            toggle_due;
   logic                            release_due;
   logic                            triac;
   logic                            relay;
   logic [1:0]                      status;

   always_comb begin
      case (phase_ff)
         rths_pkg::PH_TRIAC_ON: begin
            triac  = 1'b1;
            relay  = real_level_ff;
            status = rths_pkg::ST_TRANS;
         end
         rths_pkg::PH_RELAY_ON: begin
            triac  = 1'b1;
            relay  = 1'b1;
            status = rths_pkg::ST_TRANS;
         end
         rths_pkg::PH_RELAY_OFF: begin
            triac  = 1'b1;
            relay  = 1'b0;
            status = rths_pkg::ST_TRANS;
         end
         rths_pkg::PH_TRIAC_OFF: begin
            triac  = 1'b0;
            relay  = wanted_on;
            status = wanted_on ? rths_pkg::ST_ON : rths_pkg::ST_OFF;
         end
         default: begin
            triac  = 1'b0;
            relay  = real_level_ff;
            status = real_level_ff ? rths_pkg::ST_ON : rths_pkg::ST_OFF;
         end
      endcase
   end

   // saturating add of the tick period
   always_comb begin
      sum = rths_pkg::SUM_BITS'(elapsed_ff) + rths_pkg::SUM_BITS'(cfg.tick_period);
      if (sum[rths_pkg::SUM_BITS-1:rths_pkg::TIME_BITS] != '0)
         elapsed_step = '1;
      else
         elapsed_step = sum[rths_pkg::TIME_BITS-1:0];
      toggle_due  = rths_pkg::CMP_BITS'(elapsed_step) >=
                    rths_pkg::CMP_BITS'(cfg.relay_toggle_delay);
      release_due = rths_pkg::CMP_BITS'(elapsed_step) >=
                    rths_pkg::CMP_BITS'(cfg.triac_release_delay);
   end

   always_comb begin
      phase_in      = phase_ff;
      elapsed_in    = elapsed_step;
      real_level_in = real_level_ff;
      case (phase_ff)
         rths_pkg::PH_IDLE: begin
            if (wanted_on != real_level_ff) begin
               phase_in   = rths_pkg::PH_TRIAC_ON;
               elapsed_in = '0;
            end
         end
         rths_pkg::PH_TRIAC_ON: begin
            if (toggle_due)
               phase_in = wanted_on ? rths_pkg::PH_RELAY_ON : rths_pkg::PH_RELAY_OFF;
         end
         rths_pkg::PH_RELAY_ON,
         rths_pkg::PH_RELAY_OFF: begin
            if (release_due)
               phase_in = rths_pkg::PH_TRIAC_OFF;
         end
         rths_pkg::PH_TRIAC_OFF: begin
            real_level_in = wanted_on;
            elapsed_in    = '0;
            phase_in      = rths_pkg::PH_IDLE;
         end
         default: phase_in = rths_pkg::PH_IDLE;
      endcase
   end

   assign result.triac_drive    = triac;
   assign result.relay_drive    = relay;
   assign result.channel_status = status;
   assign result.phase_now      = rths_pkg::phase_code(phase_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= rths_pkg::PH_IDLE;
         elapsed_ff    <= '0;
         real_level_ff <= 1'b0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         elapsed_ff    <= elapsed_in;
         real_level_ff <= real_level_in;
      end
   end

   // a level change from idle starts a fresh transition
   a_start: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == rths_pkg::PH_IDLE && wanted_on != real_level_ff)
      |=> (phase_ff == rths_pkg::PH_TRIAC_ON && elapsed_ff == '0))
      else $error("transition start did not clear the elapsed counter");

   // the real level only moves when leaving triac off
   a_latch: assert property (@(posedge clock) disable iff (reset)
      (real_level_ff != $past(real_level_ff))
      |-> ($past(accept) && $past(phase_ff) == rths_pkg::PH_TRIAC_OFF))
      else $error("real level changed outside triac-off phase");

endmodule

FILE: rtl/rths_outbuf.sv
// ----------------------------------------------------------------------------
// rths_outbuf
// Two-entry result buffer (output register plus skid) so the input side
// keeps accepting while a result waits.
// ----------------------------------------------------------------------------
module rths_outbuf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  rths_pkg::result_type  in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output rths_pkg::result_type  out_data
);

   logic                 out_valid_ff, out_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   rths_pkg::result_type out_data_ff, out_data_in;
   rths_pkg::result_type skid_data_ff, skid_data_in;
   logic                 take;
   logic                 put;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign take      = out_valid_ff && out_ready;
   assign put       = in_valid && !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (put) begin
         if (!out_valid_ff || take) begin
            out_data_in  = in_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   a_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with empty output register");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && take) |=> (out_valid_ff && !skid_valid_ff
                                   && out_data_ff == $past(skid_data_ff)))
      else $error("skid entry not moved to output register");

endmodule

FILE: rtl/relay_triac_hybrid_switch_sequencer.sv
// ----------------------------------------------------------------------------
// relay_triac_hybrid_switch_sequencer
// Sequences a hybrid relay/triac switch: each input word is one tick with the
// wanted output level, each result word gives the drives and channel status.
// ----------------------------------------------------------------------------
// One result word per input word, in order. A word is taken every cycle
// while req_tready is high: the phase, elapsed-time and level registers
// update in the cycle of acceptance, and the result is registered in a
// two-entry result buffer (output register plus skid) that lets the request
// side keep going while the response side stalls; req_tready drops only
// when both entries are full. A level change fires the triac, switches the
// relay once relay_toggle_delay has elapsed, releases the triac once
// triac_release_delay has elapsed (both measured from the transition start,
// in units of tick_period per tick), then latches the new level. The
// elapsed counter saturates. Config writes are taken at once (csr_ready is
// tied high) and should be made while the block is idle.
// ----------------------------------------------------------------------------
module relay_triac_hybrid_switch_sequencer (
   input  logic                               clock,
   input  logic                               reset,
   // request: tdata[0] wanted_on, [7:1] zero
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [rths_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // response: tdata[0] triac_drive, [1] relay_drive,
   //           [3:2] channel_status, [6:4] phase_now, [7] zero
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [rths_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // configuration: index 0 tick_period, 1 relay_toggle_delay,
   //                2 triac_release_delay
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rths_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [rths_pkg::CSR_DATA_BITS-1:0] csr_data
);

   rths_pkg::cfg_type    cfg;
   rths_pkg::result_type seq_result;
   rths_pkg::result_type rsp_result;
   logic                 accept;

   assign accept = req_tvalid && req_tready;

   rths_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   rths_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .wanted_on (req_tdata[0]),
      .cfg       (cfg),
      .result    (seq_result)
   );

   rths_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (seq_result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_result)
   );

   // result struct is packed with triac_drive in the lowest bit
   assign rsp_tdata = {1'b0, rsp_result};

endmodule
